[rtl/msl_pkg.sv]
// msl_pkg: shared constants, codes and types of the mp4 sample locator
// no dependencies; imported by the divider and the top level
`timescale 1ns / 1ps

package msl_pkg;

    localparam int MAX_SAMPLES = 4096;
    localparam int MAX_CHUNKS  = 1024;
    localparam int MAX_RUNS    = 256;

    localparam int SAMPLE_AW = $clog2(MAX_SAMPLES);
    localparam int CHUNK_AW  = $clog2(MAX_CHUNKS);
    localparam int RUN_AW    = $clog2(MAX_RUNS);

    localparam int SAMPLE_CW = 13;
    localparam int CHUNK_CW  = 11;
    localparam int RUN_CW    = 9;
    localparam int CFG_W     = 13;
    localparam int CFG_IW    = 2;

    localparam logic [CFG_IW-1:0] CFG_SAMPLE_TOTAL = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_CHUNK_TOTAL  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_RUN_TOTAL    = 2'd2;

    typedef enum logic [1:0] {
        REQ_LOAD_RUN    = 2'd0,
        REQ_LOAD_SIZE   = 2'd1,
        REQ_LOAD_OFFSET = 2'd2,
        REQ_QUERY       = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        STAT_FOUND = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_MISS  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SIZE_RD,
        ST_RUN_RD,
        ST_RUN_DATA,
        ST_RUN_CMP,
        ST_DIV_WAIT,
        ST_CHECK,
        ST_OFF_RD,
        ST_OFF_DATA,
        ST_SUM_RD,
        ST_SUM_ADD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

[rtl/msl_if.sv]
// msl_req_if / msl_rsp_if: valid-ready channels of the mp4 sample locator
// no package dependency; field widths are written as literals
`timescale 1ns / 1ps

interface msl_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [11:0] index;
    logic [31:0] run_first_chunk;
    logic [31:0] run_samples_per_chunk;
    logic [31:0] size_value;
    logic [63:0] offset_value;

    modport source (output valid, req_type, index, run_first_chunk,
                    run_samples_per_chunk, size_value, offset_value, input ready);
    modport sink   (input valid, req_type, index, run_first_chunk,
                    run_samples_per_chunk, size_value, offset_value, output ready);
endinterface

interface msl_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] byte_offset;
    logic [31:0] byte_size;

    modport source (output valid, status, byte_offset, byte_size, input ready);
    modport sink   (input valid, status, byte_offset, byte_size, output ready);
endinterface

[rtl/msl_div.sv]
// msl_div: 32-bit unsigned restoring divider, one quotient bit per cycle
// depends on msl_pkg (div_stat_t)
`timescale 1ns / 1ps

module msl_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [31:0]          dividend,
    input  logic [31:0]          divisor,
    output msl_pkg::div_stat_t   stat,
    output logic [31:0]          quotient,
    output logic [31:0]          remainder
);
    import msl_pkg::*;

    logic [5:0]  count_reg, count_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [32:0] shifted;
    logic [32:0] trial;

    always_comb
    begin
        shifted    = {rem_reg, quo_reg[31]};
        trial      = shifted - {1'b0, dsr_reg};
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dsr_next   = dsr_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = 6'd32;
            rem_next   = '0;
            quo_next   = dividend;
            dsr_next   = divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            count_next = count_reg - 6'd1;
            if (count_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");
    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> count_reg != 6'd0)
        else $error("divider busy with empty count");

endmodule

[rtl/mp4_sample_locator.sv]
// mp4_sample_locator: sample-to-chunk lookup with run, size and offset tables
// depends on msl_pkg, msl_if (msl_req_if, msl_rsp_if) and msl_div
//
//   channel | dir | beat
//   req     | in  | load run entry, load sample size, load chunk offset, or query
//   rsp     | out | status, byte offset, byte size (one per query)
//   cfg     | in  | write of sample_total, chunk_total or run_total
//
// a load is written on acceptance, input kept ready; a located query holds the input
// through the walk of R runs including the hit and the sum of the S earlier samples
// in the chunk, paced by the bit-serial divider and the single size memory port
// the result sits in an output register, so a new beat is taken while it waits
// memories have no reset; counts reset to zero

`timescale 1ns / 1ps

module mp4_sample_locator (
    input  logic                         clk,
    input  logic                         rst_n,
    msl_req_if.sink                      req,
    msl_rsp_if.source                    rsp,
    input  logic                         cfg_we,
    input  logic [msl_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [msl_pkg::CFG_W-1:0]    cfg_data
);
    import msl_pkg::*;

    logic [31:0] run_first_mem [MAX_RUNS];
    logic [31:0] run_spc_mem   [MAX_RUNS];
    logic [31:0] size_mem      [MAX_SAMPLES];
    logic [63:0] offset_mem    [MAX_CHUNKS];

    logic [SAMPLE_CW-1:0] sample_total_reg;
    logic [CHUNK_CW-1:0]  chunk_total_reg;
    logic [RUN_CW-1:0]    run_total_reg;

    logic [SAMPLE_CW-1:0] ns;
    logic [CHUNK_CW-1:0]  nc;
    logic [RUN_CW-1:0]    nr;

    state_t      state_reg, state_next;
    logic [11:0] idx_reg, idx_next;
    logic [31:0] sz_reg, sz_next;
    logic [RUN_CW-1:0] run_i_reg, run_i_next;
    logic [31:0] cum_reg, cum_next;
    logic [31:0] fc_reg, fc_next;
    logic [31:0] spc_reg, spc_next;
    logic [31:0] span_reg, span_next;
    logic [31:0] rel_reg, rel_next;
    logic [31:0] chunk_reg, chunk_next;
    logic [31:0] gfic_reg, gfic_next;
    logic [31:0] sic_reg, sic_next;
    logic [SAMPLE_CW-1:0] j_reg, j_next;
    logic [63:0] acc_reg, acc_next;
    status_t     res_status_reg, res_status_next;
    logic [63:0] res_off_reg, res_off_next;
    logic [31:0] res_size_reg, res_size_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_status_reg;
    logic [63:0] out_off_reg;
    logic [31:0] out_size_reg;
    logic        out_load;

    logic [RUN_AW-1:0]    run_raddr;
    logic [RUN_AW-1:0]    run_raddr_b;
    logic [SAMPLE_AW-1:0] size_raddr;
    logic [CHUNK_AW-1:0]  off_raddr;
    logic [31:0] run_first_rdata, run_first_rdata_b, run_spc_rdata;
    logic [31:0] size_rdata;
    logic [63:0] off_rdata;

    logic        accept;
    logic        div_start;
    div_stat_t   div_stat;
    logic [31:0] div_quo, div_rem;

    logic [31:0] end_fc;
    logic [31:0] rel;
    logic [32:0] last_sample;

    assign ns = (sample_total_reg > SAMPLE_CW'(MAX_SAMPLES)) ?
                SAMPLE_CW'(MAX_SAMPLES) : sample_total_reg;
    assign nc = (chunk_total_reg > CHUNK_CW'(MAX_CHUNKS)) ?
                CHUNK_CW'(MAX_CHUNKS) : chunk_total_reg;
    assign nr = (run_total_reg > RUN_CW'(MAX_RUNS)) ?
                RUN_CW'(MAX_RUNS) : run_total_reg;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_total_reg <= '0;
            chunk_total_reg  <= '0;
            run_total_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SAMPLE_TOTAL: sample_total_reg <= cfg_data;
                CFG_CHUNK_TOTAL:  chunk_total_reg  <= cfg_data[CHUNK_CW-1:0];
                CFG_RUN_TOTAL:    run_total_reg    <= cfg_data[RUN_CW-1:0];
                default:          ;
            endcase
        end
    end

    // table memories
    always_ff @(posedge clk)
    begin
        if (accept && req.req_type == REQ_LOAD_RUN && req.index < 12'(MAX_RUNS))
        begin
            run_first_mem[req.index[RUN_AW-1:0]] <= req.run_first_chunk;
            run_spc_mem[req.index[RUN_AW-1:0]]   <= req.run_samples_per_chunk;
        end
        run_first_rdata   <= run_first_mem[run_raddr];
        run_first_rdata_b <= run_first_mem[run_raddr_b];
        run_spc_rdata     <= run_spc_mem[run_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (accept && req.req_type == REQ_LOAD_SIZE)
            size_mem[req.index[SAMPLE_AW-1:0]] <= req.size_value;
        size_rdata <= size_mem[size_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (accept && req.req_type == REQ_LOAD_OFFSET && req.index < 12'(MAX_CHUNKS))
            offset_mem[req.index[CHUNK_AW-1:0]] <= req.offset_value;
        off_rdata <= offset_mem[off_raddr];
    end

    assign run_raddr   = run_i_reg[RUN_AW-1:0];
    assign run_raddr_b = run_i_reg[RUN_AW-1:0] + RUN_AW'(1);
    assign size_raddr  = (state_reg == ST_SUM_RD) ?
                         gfic_reg[SAMPLE_AW-1:0] + j_reg[SAMPLE_AW-1:0] :
                         idx_reg[SAMPLE_AW-1:0];
    assign off_raddr   = chunk_reg[CHUNK_AW-1:0];

    msl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rel),
        .divisor   (spc_reg),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // last run ends one past the chunk count
    assign end_fc = ({23'd0, run_i_reg} + 32'd1 < {23'd0, nr}) ?
                    run_first_rdata_b : {21'd0, nc} + 32'd1;
    assign rel         = {20'd0, idx_reg} - cum_reg;
    assign last_sample = {1'b0, gfic_reg} + {1'b0, sic_reg};

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        sz_next         = sz_reg;
        run_i_next      = run_i_reg;
        cum_next        = cum_reg;
        fc_next         = fc_reg;
        spc_next        = spc_reg;
        span_next       = span_reg;
        rel_next        = rel_reg;
        chunk_next      = chunk_reg;
        gfic_next       = gfic_reg;
        sic_next        = sic_reg;
        j_next          = j_reg;
        acc_next        = acc_reg;
        res_status_next = res_status_reg;
        res_off_next    = res_off_reg;
        res_size_next   = res_size_reg;
        div_start       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && req.req_type == REQ_QUERY)
                begin
                    idx_next = req.index;
                    if ({1'b0, req.index} >= ns)
                    begin
                        res_status_next = STAT_RANGE;
                        res_off_next    = '0;
                        res_size_next   = '0;
                        state_next      = ST_OUT;
                    end
                    else
                        state_next = ST_SIZE_RD;
                end
            end
            ST_SIZE_RD:
            begin
                run_i_next = '0;
                cum_next   = '0;
                state_next = ST_RUN_RD;
            end
            ST_RUN_RD:
            begin
                sz_next = size_rdata;
                if (run_i_reg >= nr)
                begin
                    res_status_next = STAT_MISS;
                    res_off_next    = '0;
                    res_size_next   = size_rdata;
                    state_next      = ST_OUT;
                end
                else
                    state_next = ST_RUN_DATA;
            end
            ST_RUN_DATA:
            begin
                fc_next    = run_first_rdata;
                spc_next   = run_spc_rdata;
                span_next  = 32'((end_fc - run_first_rdata) * run_spc_rdata);
                state_next = ST_RUN_CMP;
            end
            ST_RUN_CMP:
            begin
                if (rel < span_reg)
                begin
                    rel_next   = rel;
                    div_start  = 1'b1;
                    state_next = ST_DIV_WAIT;
                end
                else
                begin
                    cum_next   = cum_reg + span_reg;
                    run_i_next = run_i_reg + RUN_CW'(1);
                    state_next = ST_RUN_RD;
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    chunk_next = fc_reg - 32'd1 + div_quo;
                    sic_next   = div_rem;
                    // ci*spc equals rel minus the remainder
                    gfic_next  = cum_reg + rel_reg - div_rem;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (chunk_reg >= {21'd0, nc} ||
                    (sic_reg != 32'd0 && last_sample > {20'd0, ns}))
                begin
                    res_status_next = STAT_MISS;
                    res_off_next    = '0;
                    res_size_next   = sz_reg;
                    state_next      = ST_OUT;
                end
                else
                    state_next = ST_OFF_RD;
            end
            ST_OFF_RD:
                state_next = ST_OFF_DATA;
            ST_OFF_DATA:
            begin
                acc_next   = off_rdata;
                j_next     = '0;
                state_next = ST_SUM_RD;
            end
            ST_SUM_RD:
            begin
                if ({19'd0, j_reg} == sic_reg)
                begin
                    res_status_next = STAT_FOUND;
                    res_off_next    = acc_reg;
                    res_size_next   = sz_reg;
                    state_next      = ST_OUT;
                end
                else
                    state_next = ST_SUM_ADD;
            end
            ST_SUM_ADD:
            begin
                acc_next   = acc_reg + {32'd0, size_rdata};
                j_next     = j_reg + SAMPLE_CW'(1);
                state_next = ST_SUM_RD;
            end
            ST_OUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        sz_reg         <= sz_next;
        run_i_reg      <= run_i_next;
        cum_reg        <= cum_next;
        fc_reg         <= fc_next;
        spc_reg        <= spc_next;
        span_reg       <= span_next;
        rel_reg        <= rel_next;
        chunk_reg      <= chunk_next;
        gfic_reg       <= gfic_next;
        sic_reg        <= sic_next;
        j_reg          <= j_next;
        acc_reg        <= acc_next;
        res_status_reg <= res_status_next;
        res_off_reg    <= res_off_next;
        res_size_reg   <= res_size_next;
    end

    // output register
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_off_reg    <= res_off_reg;
            out_size_reg   <= res_size_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.byte_offset = out_off_reg;
    assign rsp.byte_size   = out_size_reg;

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == STAT_RANGE |-> rsp.byte_size == 32'd0 &&
        rsp.byte_offset == 64'd0)
        else $error("out-of-range beat carries nonzero fields");
    a_miss_offset: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != STAT_FOUND |-> rsp.byte_offset == 64'd0)
        else $error("offset given without a found sample");
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.req_type == REQ_QUERY |=> state_reg != ST_IDLE)
        else $error("query accepted but sequencer stayed idle");
    a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> state_reg == ST_DIV_WAIT)
        else $error("divider running outside the divide step");

endmodule
